>>> design/dprs_pkg.sv
// ----------------------------------------------------------------------------
// dprs_pkg: shared types and constants of the dual pattern region scanner
// Payload structs, configuration register codes, pattern configuration and
// the upper-case fold used on both the data bytes and the pattern bytes.
// ----------------------------------------------------------------------------
package dprs_pkg;

   // Window depth in bytes and bytes held by the pattern registers
   localparam int PATTERN_BYTES = 16;
   localparam int REG_BYTES     = 16;
   // Longest pattern that can match at all
   localparam int LEN_MAX       = (PATTERN_BYTES < REG_BYTES) ? PATTERN_BYTES : REG_BYTES;
   // Byte count within the region saturates at PATTERN_BYTES
   localparam int CNT_W         = $clog2(PATTERN_BYTES + 1);
   localparam int LEN_W         = 5;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 3;

   // Lower-case letter range and the distance to upper case
   localparam logic [7:0] FOLD_LOW    = 8'h61;
   localparam logic [7:0] FOLD_HIGH   = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   // Configuration register codes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FIRST_LOW   = 3'd0,
      CSR_FIRST_HIGH  = 3'd1,
      CSR_FIRST_LEN   = 3'd2,
      CSR_SECOND_LOW  = 3'd3,
      CSR_SECOND_HIGH = 3'd4,
      CSR_SECOND_LEN  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       region_end;
   } req_payload_type;

   typedef struct packed {
      logic detected;
      logic first_seen;
      logic second_seen;
   } rsp_payload_type;

   // One pattern: raw bytes (byte 0 in the low bits) and its length
   typedef struct packed {
      logic [REG_BYTES*8-1:0] bytes;
      logic [LEN_W-1:0]       length;
   } pattern_cfg_type;

   // Folded bytes of the region, newest in entry 0
   typedef logic [PATTERN_BYTES-1:0][7:0] window_type;

   // Control of the window stage as seen by the result stage
   typedef struct packed {
      logic valid;
      logic region_end;
   } stage_ctl_type;

   // Fold a to z to upper case, leave every other byte alone
   function automatic logic [7:0] fold_upper(logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= FOLD_LOW && b <= FOLD_HIGH) begin
         r = b - CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

>>> design/dprs_csr.sv
// ----------------------------------------------------------------------------
// dprs_csr: configuration registers
// Holds both patterns and their lengths; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module dprs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dprs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dprs_pkg::CSR_DATA_W-1:0]   csr_data,
   output dprs_pkg::pattern_cfg_type         first_cfg,
   output dprs_pkg::pattern_cfg_type         second_cfg
);

   dprs_pkg::pattern_cfg_type first_ff;
   dprs_pkg::pattern_cfg_type second_ff;

   // Always take a write transfer
   assign csr_ready = 1'b1;

   // Update the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         second_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            dprs_pkg::CSR_FIRST_LOW: begin
               first_ff.bytes[63:0] <= csr_data;
            end
            dprs_pkg::CSR_FIRST_HIGH: begin
               first_ff.bytes[127:64] <= csr_data;
            end
            dprs_pkg::CSR_FIRST_LEN: begin
               first_ff.length <= csr_data[dprs_pkg::LEN_W-1:0];
            end
            dprs_pkg::CSR_SECOND_LOW: begin
               second_ff.bytes[63:0] <= csr_data;
            end
            dprs_pkg::CSR_SECOND_HIGH: begin
               second_ff.bytes[127:64] <= csr_data;
            end
            dprs_pkg::CSR_SECOND_LEN: begin
               second_ff.length <= csr_data[dprs_pkg::LEN_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign first_cfg  = first_ff;
   assign second_cfg = second_ff;

endmodule

>>> design/dprs_window.sv
// ----------------------------------------------------------------------------
// dprs_window: input register stage
// Folds each byte, shifts it into the window of recent region bytes and keeps
// the saturating count of bytes seen in the current region.
// ----------------------------------------------------------------------------
module dprs_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dprs_pkg::req_payload_type     req_data,
   input  logic                          stage_go,
   output dprs_pkg::stage_ctl_type       stage_ctl,
   output dprs_pkg::window_type          window,
   output logic [dprs_pkg::CNT_W-1:0]    count
);

   dprs_pkg::window_type           window_ff;
   dprs_pkg::window_type           window_in;
   logic [dprs_pkg::CNT_W-1:0]     count_ff;
   logic [dprs_pkg::CNT_W-1:0]     count_in;
   logic [dprs_pkg::CNT_W-1:0]     count_base;
   logic                           valid_ff;
   logic                           valid_in;
   logic                           end_ff;
   logic                           end_in;
   logic                           accept;

   // Take a new byte when the stage is empty or drains this cycle
   assign req_ready = !valid_ff || stage_go;
   assign accept    = req_valid && req_ready;

   // Shift in the folded byte, restart the count after a region end
   always_comb begin
      window_in  = window_ff;
      count_in   = count_ff;
      end_in     = end_ff;
      valid_in   = valid_ff && !stage_go;
      count_base = end_ff ? '0 : count_ff;
      if (accept) begin
         for (int i = dprs_pkg::PATTERN_BYTES - 1; i > 0; i--) begin
            window_in[i] = window_ff[i-1];
         end
         window_in[0] = dprs_pkg::fold_upper(req_data.data_byte);
         if (count_base == dprs_pkg::CNT_W'(dprs_pkg::PATTERN_BYTES)) begin
            count_in = count_base;
         end else begin
            count_in = count_base + 1'b1;
         end
         end_in   = req_data.region_end;
         valid_in = 1'b1;
      end
   end

   // Window bytes beyond the count are never compared, so they need no reset
   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         end_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         end_ff   <= end_in;
         valid_ff <= valid_in;
      end
   end

   assign stage_ctl.valid      = valid_ff;
   assign stage_ctl.region_end = end_ff;
   assign window               = window_ff;
   assign count                = count_ff;

endmodule

>>> design/dprs_match.sv
// ----------------------------------------------------------------------------
// dprs_match: pattern compare
// Flags when one configured pattern ends at the newest byte of the window,
// comparing every pattern length in parallel and picking the configured one.
// ----------------------------------------------------------------------------
module dprs_match (
   input  dprs_pkg::window_type          window,
   input  logic [dprs_pkg::CNT_W-1:0]    count,
   input  dprs_pkg::pattern_cfg_type     cfg,
   output logic                          hit
);

   logic [dprs_pkg::REG_BYTES-1:0][7:0] pat_fold;
   logic                                ok;

   // Fold the pattern bytes like the data
   always_comb begin
      for (int k = 0; k < dprs_pkg::REG_BYTES; k++) begin
         pat_fold[k] = dprs_pkg::fold_upper(cfg.bytes[k*8 +: 8]);
      end
   end

   // Check each length; zero and overlong lengths select nothing
   always_comb begin
      hit = 1'b0;
      ok  = 1'b0;
      for (int n = 1; n <= dprs_pkg::LEN_MAX; n++) begin
         ok = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (window[n-1-i] != pat_fold[i]) begin
               ok = 1'b0;
            end
         end
         if (cfg.length == dprs_pkg::LEN_W'(n)
             && count >= dprs_pkg::CNT_W'(n)) begin
            hit = ok;
         end
      end
   end

endmodule

>>> design/dprs_result.sv
// ----------------------------------------------------------------------------
// dprs_result: result register stage
// Collects the per-region found flags and loads the result register at the
// region's last byte, then clears the flags for the next region.
// ----------------------------------------------------------------------------
module dprs_result (
   input  logic                          clock,
   input  logic                          reset,
   input  dprs_pkg::stage_ctl_type       stage_ctl,
   input  logic                          first_hit,
   input  logic                          second_hit,
   output logic                          stage_go,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dprs_pkg::rsp_payload_type     rsp_data
);

   logic                       first_ff;
   logic                       first_in;
   logic                       second_ff;
   logic                       second_in;
   logic                       first_now;
   logic                       second_now;
   logic                       valid_ff;
   logic                       valid_in;
   dprs_pkg::rsp_payload_type  data_ff;
   dprs_pkg::rsp_payload_type  data_in;

   // Middle bytes always drain; a region end waits for a free result register
   assign stage_go = stage_ctl.valid
                     && (!stage_ctl.region_end || !valid_ff || rsp_ready);

   assign first_now  = first_ff || first_hit;
   assign second_now = second_ff || second_hit;

   // Fold hits into the flags and hand out the result at the region end
   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      data_in   = data_ff;
      valid_in  = valid_ff && !rsp_ready;
      if (stage_go) begin
         if (stage_ctl.region_end) begin
            data_in.detected    = first_now && second_now;
            data_in.first_seen  = first_now;
            data_in.second_seen = second_now;
            valid_in            = 1'b1;
            first_in            = 1'b0;
            second_in           = 1'b0;
         end else begin
            first_in  = first_now;
            second_in = second_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= 1'b0;
         second_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
         valid_ff  <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> design/dual_pattern_region_scanner_top.sv
// ----------------------------------------------------------------------------
// dual_pattern_region_scanner_top: case-insensitive two-pattern region scan
// Takes region bytes one per transfer and reports, at each region's last
// byte, which of the two configured patterns occurred inside that region.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req      in         req_valid / req_ready  req_data  (data_byte, region_end)
//  rsp      out        rsp_valid / rsp_ready  rsp_data  (detected, first/second_seen)
//  csr      in         csr_valid / csr_ready  csr_index, csr_data
//
//  One byte per cycle while no region end is stalled: a transfer lands in the window
//  register, the pattern compare is combinational and the result register is loaded from it.
//  A result is valid once the region's last byte has passed the window and result registers.
//  Synchronous reset clears the count, found flags, valid bits and patterns.
//  A held result stalls only a following region end; middle bytes keep flowing.
// ----------------------------------------------------------------------------
module dual_pattern_region_scanner_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  dprs_pkg::req_payload_type         req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output dprs_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dprs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dprs_pkg::CSR_DATA_W-1:0]   csr_data
);

   dprs_pkg::pattern_cfg_type     first_cfg;
   dprs_pkg::pattern_cfg_type     second_cfg;
   dprs_pkg::stage_ctl_type       stage_ctl;
   dprs_pkg::window_type          window;
   logic [dprs_pkg::CNT_W-1:0]    count;
   logic                          stage_go;
   logic                          first_hit;
   logic                          second_hit;

   // Configuration registers
   dprs_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .first_cfg  (first_cfg),
      .second_cfg (second_cfg)
   );

   // Input stage with the byte window
   dprs_window u_window (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .stage_go  (stage_go),
      .stage_ctl (stage_ctl),
      .window    (window),
      .count     (count)
   );

   // Pattern compares
   dprs_match u_match_first (
      .window (window),
      .count  (count),
      .cfg    (first_cfg),
      .hit    (first_hit)
   );

   dprs_match u_match_second (
      .window (window),
      .count  (count),
      .cfg    (second_cfg),
      .hit    (second_hit)
   );

   // Flags and result register
   dprs_result u_result (
      .clock      (clock),
      .reset      (reset),
      .stage_ctl  (stage_ctl),
      .first_hit  (first_hit),
      .second_hit (second_hit),
      .stage_go   (stage_go),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

>>> dv/region_scan_checker.sv
// ----------------------------------------------------------------------------
// region_scan_checker: result predictor and comparator for the region scanner
// Watches the register, byte and result channels, keeps its own copy of the
// pattern registers and the byte window, predicts the verdict of each region
// and compares every result transfer against the oldest predicted verdict.
// ----------------------------------------------------------------------------
module region_scan_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  dprs_pkg::req_payload_type         req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  dprs_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [dprs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dprs_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                                mismatch_count,
   output int                                verdicts_pending,
   output int                                verdicts_checked,
   output int                                both_seen_count,
   output int                                first_seen_count,
   output int                                second_seen_count
);

   // Shadow copy of the pattern registers
   logic [dprs_pkg::REG_BYTES*8-1:0] first_pat;
   logic [dprs_pkg::REG_BYTES*8-1:0] second_pat;
   logic [dprs_pkg::LEN_W-1:0]       first_len;
   logic [dprs_pkg::LEN_W-1:0]       second_len;

   // Predicted scan state
   dprs_pkg::window_type             folded_window;
   int                               window_fill;
   logic                             first_hit;
   logic                             second_hit;

   // Predicted verdicts, oldest first
   dprs_pkg::rsp_payload_type        region_verdicts_q [$];

   // Fold a to z onto A to Z
   function automatic logic [7:0] upcase(input logic [7:0] raw);
      if (raw >= dprs_pkg::FOLD_LOW && raw <= dprs_pkg::FOLD_HIGH) begin
         return raw - dprs_pkg::CASE_OFFSET;
      end
      return raw;
   endfunction

   // True when the pattern ends at the newest byte of the window
   function automatic logic pattern_ends_here(
         input logic [dprs_pkg::REG_BYTES*8-1:0] pat,
         input logic [dprs_pkg::LEN_W-1:0]       len);
      int   n;
      logic hit;
      n   = int'(len);
      hit = (n != 0) && (n <= dprs_pkg::LEN_MAX) && (window_fill >= n);
      if (hit) begin
         for (int i = 0; i < n; i++) begin
            if (folded_window[n-1-i] != upcase(pat[8*i +: 8])) begin
               hit = 1'b0;
            end
         end
      end
      return hit;
   endfunction

   // Shift one byte into the window and queue a verdict at the region end
   task automatic absorb_byte(input dprs_pkg::req_payload_type item);
      dprs_pkg::rsp_payload_type verdict;
      folded_window = {folded_window[dprs_pkg::PATTERN_BYTES-2:0],
                       upcase(item.data_byte)};
      if (window_fill < dprs_pkg::PATTERN_BYTES) begin
         window_fill++;
      end
      if (pattern_ends_here(first_pat, first_len)) begin
         first_hit = 1'b1;
      end
      if (pattern_ends_here(second_pat, second_len)) begin
         second_hit = 1'b1;
      end
      if (item.region_end) begin
         verdict.detected    = first_hit & second_hit;
         verdict.first_seen  = first_hit;
         verdict.second_seen = second_hit;
         region_verdicts_q.push_back(verdict);
         first_hit   = 1'b0;
         second_hit  = 1'b0;
         window_fill = 0;
      end
   endtask

   always @(posedge clock) begin
      dprs_pkg::rsp_payload_type want;
      if (reset) begin
         first_pat         = '0;
         second_pat        = '0;
         first_len         = '0;
         second_len        = '0;
         folded_window     = '0;
         window_fill       = 0;
         first_hit         = 1'b0;
         second_hit        = 1'b0;
         mismatch_count    = 0;
         verdicts_checked  = 0;
         both_seen_count   = 0;
         first_seen_count  = 0;
         second_seen_count = 0;
         region_verdicts_q.delete();
      end else begin
         // Mirror register writes; spare indexes are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dprs_pkg::CSR_FIRST_LOW:   first_pat[63:0]    = csr_data;
               dprs_pkg::CSR_FIRST_HIGH:  first_pat[127:64]  = csr_data;
               dprs_pkg::CSR_FIRST_LEN:   first_len          = csr_data[dprs_pkg::LEN_W-1:0];
               dprs_pkg::CSR_SECOND_LOW:  second_pat[63:0]   = csr_data;
               dprs_pkg::CSR_SECOND_HIGH: second_pat[127:64] = csr_data;
               dprs_pkg::CSR_SECOND_LEN:  second_len         = csr_data[dprs_pkg::LEN_W-1:0];
               default: ;
            endcase
         end

         // Compare each result transfer with the oldest verdict
         if (rsp_valid && rsp_ready) begin
            if (region_verdicts_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: unexpected result detected=%b first=%b second=%b",
                           rsp_data.detected, rsp_data.first_seen, rsp_data.second_seen);
               end
            end else begin
               want = region_verdicts_q.pop_front();
               verdicts_checked++;
               if (want.detected)    both_seen_count++;
               if (want.first_seen)  first_seen_count++;
               if (want.second_seen) second_seen_count++;
               if (rsp_data.detected !== want.detected ||
                   rsp_data.first_seen !== want.first_seen ||
                   rsp_data.second_seen !== want.second_seen) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: region %0d expected d=%b f=%b s=%b, got d=%b f=%b s=%b",
                              verdicts_checked, want.detected, want.first_seen,
                              want.second_seen, rsp_data.detected,
                              rsp_data.first_seen, rsp_data.second_seen);
                  end
               end
            end
         end

         // Predict from each accepted byte
         if (req_valid && req_ready) begin
            absorb_byte(req_data);
         end
      end
      verdicts_pending <= region_verdicts_q.size();
   end

endmodule

>>> dv/tb_dual_pattern_region_scanner_top.sv
// ----------------------------------------------------------------------------
// tb_dual_pattern_region_scanner_top: stimulus and verdict for the scanner
// Loads pattern settings between phases, streams directed and random regions
// with embedded, broken and region-straddling pattern copies under several
// flow-control modes, and reports the checker's outcome.
// ----------------------------------------------------------------------------
module tb_dual_pattern_region_scanner_top;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 165;

   // Register indexes beyond the defined set
   localparam logic [dprs_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 3'd6;
   localparam logic [dprs_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 3'd7;

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH
   } flow_mode_type;

   typedef enum int {
      FILL_LETTERS,
      FILL_RANDOM,
      FILL_ONES,
      FILL_ZEROS
   } fill_kind_type;

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   dprs_pkg::req_payload_type           req_data  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   dprs_pkg::rsp_payload_type           rsp_data;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [dprs_pkg::CSR_INDEX_W-1:0]    csr_index = '0;
   logic [dprs_pkg::CSR_DATA_W-1:0]     csr_data  = '0;

   int                          mismatch_count;
   int                          verdicts_pending;
   int                          verdicts_checked;
   int                          both_seen_count;
   int                          first_seen_count;
   int                          second_seen_count;

   int                          sender_idle_pct    = 0;
   int                          receiver_stall_pct = 0;
   int unsigned                 cycle_count        = 0;
   int                          bytes_sent         = 0;
   int                          settings_loaded    = 0;

   // Current patterns as loaded, for embedding into regions
   logic [dprs_pkg::REG_BYTES*8-1:0] pat_bytes [2];
   int                               pat_len [2];
   // Tail of a pattern copy cut off by a region end
   logic [7:0]                       spill_q [$];

   dual_pattern_region_scanner_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   region_scan_checker verdict_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data          (rsp_data),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .verdicts_pending  (verdicts_pending),
      .verdicts_checked  (verdicts_checked),
      .both_seen_count   (both_seen_count),
      .first_seen_count  (first_seen_count),
      .second_seen_count (second_seen_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result channel at the current rate
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Flip the case of a letter at random, leave other bytes alone
   function automatic logic [7:0] vary_case(input logic [7:0] b);
      if (((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)) &&
          $urandom_range(1) == 1) begin
         return b ^ 8'h20;
      end
      return b;
   endfunction

   // Small letter alphabet in mixed case, so random text hits short patterns
   function automatic logic [7:0] pick_letter();
      return vary_case(8'h41 + 8'($urandom_range(2)));
   endfunction

   function automatic logic [7:0] pick_data_byte();
      if ($urandom_range(99) < 40) begin
         return 8'($urandom_range(255));
      end
      return pick_letter();
   endfunction

   function automatic logic [dprs_pkg::REG_BYTES*8-1:0] make_pattern(
         input fill_kind_type kind);
      logic [dprs_pkg::REG_BYTES*8-1:0] bits;
      for (int i = 0; i < dprs_pkg::REG_BYTES; i++) begin
         case (kind)
            FILL_LETTERS: bits[8*i +: 8] = pick_letter();
            FILL_RANDOM:  bits[8*i +: 8] = 8'($urandom_range(255));
            FILL_ONES:    bits[8*i +: 8] = 8'hFF;
            default:      bits[8*i +: 8] = 8'h00;
         endcase
      end
      return bits;
   endfunction

   // Hold one register write until it transfers; valid stays up for the next
   task automatic write_reg(input logic [dprs_pkg::CSR_INDEX_W-1:0] index,
                            input logic [dprs_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Load one pattern; the length word carries random upper bits
   task automatic load_pattern(input int k,
                               input logic [dprs_pkg::REG_BYTES*8-1:0] bits,
                               input int len);
      logic [dprs_pkg::CSR_DATA_W-1:0] len_word;
      len_word                     = {$urandom, $urandom};
      len_word[dprs_pkg::LEN_W-1:0] = len[dprs_pkg::LEN_W-1:0];
      pat_bytes[k]                 = bits;
      pat_len[k]                   = len;
      write_reg((k == 0) ? dprs_pkg::CSR_FIRST_LOW : dprs_pkg::CSR_SECOND_LOW,
                bits[63:0]);
      write_reg((k == 0) ? dprs_pkg::CSR_FIRST_HIGH : dprs_pkg::CSR_SECOND_HIGH,
                bits[127:64]);
      write_reg((k == 0) ? dprs_pkg::CSR_FIRST_LEN : dprs_pkg::CSR_SECOND_LEN,
                len_word);
   endtask

   // Offer one byte after an optional idle gap and wait for its transfer
   task automatic send_byte(input logic [7:0] value, input logic last);
      dprs_pkg::req_payload_type item;
      item.data_byte  = value;
      item.region_end = last;
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // Drop valid, wait until every verdict has come back, then let the pipe empty
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (verdicts_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Build a region of random text with whole, broken and overhanging copies
   task automatic send_region(input int n);
      logic [7:0] body [48];
      logic [7:0] pb;
      int         plen;
      int         at;
      int         brk;
      for (int i = 0; i < n; i++) begin
         body[i] = (spill_q.size() != 0) ? spill_q.pop_front() : pick_data_byte();
      end
      spill_q.delete();
      for (int k = 0; k < 2; k++) begin
         if ($urandom_range(99) < 55) begin
            plen = (pat_len[k] == 0 || pat_len[k] > dprs_pkg::REG_BYTES)
                   ? dprs_pkg::REG_BYTES : pat_len[k];
            at   = (n >= plen && $urandom_range(1) == 1) ? $urandom_range(n - plen)
                                                         : $urandom_range(n - 1);
            brk  = ($urandom_range(3) == 0) ? $urandom_range(plen - 1) : -1;
            for (int j = 0; j < plen; j++) begin
               pb = (j == brk) ? 8'($urandom_range(255)) : vary_case(pat_bytes[k][8*j +: 8]);
               if (at + j < n) begin
                  body[at + j] = pb;
               end else begin
                  spill_q.push_back(pb);
               end
            end
         end
      end
      for (int i = 0; i < n; i++) begin
         send_byte(body[i], i == n - 1);
      end
   endtask

   initial begin
      logic [7:0]                       burst [20];
      logic [dprs_pkg::REG_BYTES*8-1:0] shared;
      int                               target;
      int                               shared_len;
      logic                             paused;
      flow_mode_type                    mode;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero-length patterns never match
      settings_loaded++;
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain_results();

      // Directed settings: mixed-case short pattern and a full-width one
      // made of fold boundary bytes; then writes to the spare indexes
      settings_loaded++;
      write_reg(dprs_pkg::CSR_FIRST_LOW, 64'h0000_0000_0063_4261);
      write_reg(dprs_pkg::CSR_FIRST_HIGH, {$urandom, $urandom});
      write_reg(dprs_pkg::CSR_FIRST_LEN, 64'hFFFF_FFFF_FFFF_FFE3);
      write_reg(dprs_pkg::CSR_SECOND_LOW, 64'h5A41_5B40_7B60_FF00);
      write_reg(dprs_pkg::CSR_SECOND_HIGH, 64'h3F20_7FFA_E180_7A61);
      write_reg(dprs_pkg::CSR_SECOND_LEN, 64'd16);
      write_reg(CSR_SPARE_LOW, {$urandom, $urandom});
      write_reg(CSR_SPARE_HIGH, {$urandom, $urandom});
      csr_valid <= 1'b0;
      @(posedge clock);

      // Mixed-case hit of the short pattern at the region end
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h43, 1'b1);
      // Pattern split across two regions must not count
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b1);
      send_byte(8'h43, 1'b1);
      // Both patterns in one region, the long one in the opposite case
      burst = '{8'h58, 8'h61, 8'h62, 8'h63, 8'h00, 8'hFF, 8'h60, 8'h7B, 8'h40, 8'h5B,
                8'h61, 8'h7A, 8'h41, 8'h5A, 8'h80, 8'hE1, 8'hFA, 8'h7F, 8'h20, 8'h3F};
      for (int i = 0; i < 20; i++) begin
         send_byte(burst[i], i == 19);
      end
      drain_results();

      // Random phases, each with its own settings and flow-control mode
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         settings_loaded++;
         case (ph)
            0: begin
               load_pattern(0, make_pattern(FILL_LETTERS), 16);
               load_pattern(1, make_pattern(FILL_LETTERS), 1);
            end
            1: begin
               load_pattern(0, make_pattern(FILL_RANDOM), 0);
               load_pattern(1, make_pattern(FILL_RANDOM), 16);
            end
            2: begin
               load_pattern(0, make_pattern(FILL_LETTERS), 17);
               load_pattern(1, make_pattern(FILL_LETTERS), 31);
            end
            3: begin
               load_pattern(0, make_pattern(FILL_LETTERS), $urandom_range(2, 6));
               load_pattern(1, make_pattern(FILL_LETTERS), $urandom_range(2, 6));
            end
            4: begin
               load_pattern(0, make_pattern(FILL_ONES), 16);
               load_pattern(1, make_pattern(FILL_ZEROS), 3);
            end
            5: begin
               shared     = make_pattern(FILL_LETTERS);
               shared_len = $urandom_range(1, 16);
               load_pattern(0, shared, shared_len);
               load_pattern(1, shared, shared_len);
            end
            6: begin
               load_pattern(0, make_pattern(FILL_LETTERS), $urandom_range(1, 16));
               load_pattern(1, make_pattern(FILL_LETTERS), $urandom_range(1, 16));
            end
            default: begin
               load_pattern(0, make_pattern(FILL_LETTERS), $urandom_range(1, 16));
               load_pattern(1, make_pattern(FILL_RANDOM), $urandom_range(0, 31));
               write_reg(CSR_SPARE_LOW, {$urandom, $urandom});
               write_reg(CSR_SPARE_HIGH, {$urandom, $urandom});
            end
         endcase
         csr_valid <= 1'b0;
         spill_q.delete();

         mode = flow_mode_type'(ph % 4);
         case (mode)
            FLOW_FREE:           begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            FLOW_SENDER_IDLE:    begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
            FLOW_RECEIVER_STALL: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
            default:             begin sender_idle_pct = 15; receiver_stall_pct = 15; end
         endcase
         @(posedge clock);

         // Stream regions; halfway through, hold off until all verdicts are in
         target = bytes_sent + PHASE_ITEMS;
         paused = 1'b0;
         while (bytes_sent < target) begin
            if (!paused && bytes_sent >= target - PHASE_ITEMS / 2) begin
               drain_results();
               paused = 1'b1;
            end
            send_region(($urandom_range(9) == 0) ? $urandom_range(17, 40)
                                                 : $urandom_range(1, 20));
         end
         drain_results();
      end

      $display("Scanned %0d bytes in %0d regions over %0d pattern settings, four flow modes.",
               bytes_sent, verdicts_checked, settings_loaded);
      $display("Regions holding the first pattern: %0d, the second: %0d, both: %0d.",
               first_seen_count, second_seen_count, both_seen_count);
      if (mismatch_count == 0 && verdicts_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

>>> dual_pattern_region_scanner_top.f
design/dprs_pkg.sv
design/dprs_csr.sv
design/dprs_window.sv
design/dprs_match.sv
design/dprs_result.sv
design/dual_pattern_region_scanner_top.sv
dv/region_scan_checker.sv
dv/tb_dual_pattern_region_scanner_top.sv
